// ===== design/ccsoc_pkg.sv =====
// Shared types, constants and helpers for the coulomb counter.
package ccsoc_pkg;

   localparam int unsigned CUR_W   = 16;
   localparam int unsigned TIME_W  = 48;
   localparam int unsigned SUM_W   = 17;
   localparam int unsigned GAIN_W  = 32;
   localparam int unsigned ETA_W   = 17;
   localparam int unsigned SOC_W   = 33;
   localparam int unsigned MAG_W   = 35;
   localparam int unsigned PROD_W  = 64;
   localparam int unsigned HALF_W  = 24;
   localparam int unsigned PART_W  = SUM_W + HALF_W;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 40;

   localparam logic [SOC_W-1:0] SOC_FULL  = {1'b1, 32'd0};
   localparam logic [MAG_W-1:0] MAG_CAP   = {1'b1, 34'd0};
   localparam logic [ETA_W-1:0] ETA_MIN   = 17'd32768;
   localparam logic [ETA_W-1:0] ETA_MAX   = 17'd65536;
   localparam logic [ETA_W-1:0] ETA_RESET = 17'd65222;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHARGE_GAIN   = 2'd0,
      CSR_ETA_CHARGE    = 2'd1,
      CSR_ETA_DISCHARGE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] charge_gain;
      logic [ETA_W-1:0]  chg_eff;
      logic [ETA_W-1:0]  dis_eff;
   } cfg_type;

   typedef struct packed {
      logic              first;
      logic              discharge;
      logic              round_up;
      logic [SUM_W-1:0]  abs_sum;
      logic [TIME_W-1:0] dt;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type data;
   } push_type;

   typedef struct packed {
      logic     valid;
      item_type data;
   } pop_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_DL,
      ST_MUL_DH,
      ST_ADD_A,
      ST_MUL_GL,
      ST_MUL_GH,
      ST_SUM,
      ST_MUL_ETA,
      ST_UPDATE
   } back_state_type;

   function automatic logic [ETA_W-1:0] clamp_eta(input logic [CSR_DATA_W-1:0] value);
      logic [ETA_W-1:0] e;
      e = value[ETA_W-1:0];
      if (e < ETA_MIN) begin
         e = ETA_MIN;
      end else if (e > ETA_MAX) begin
         e = ETA_MAX;
      end
      return e;
   endfunction

endpackage

// ===== design/coulomb_counter_soc_top.sv =====
// Coulomb counter top level: control registers, front end, queue and back end.
// The back end runs its multiply sequence on one request at a time; the first sample goes straight to the update.
// The front end keeps accepting requests into the queue while the back end is busy.
// The queue lets the front end accept up to QUEUE_DEPTH requests ahead of the back end.
// Reset (synchronous): SOC full, not primed, gain 0, both efficiencies 65222.
module coulomb_counter_soc_top
   import ccsoc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // current_ma[15:0], time_us[63:16]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // soc[32:0], clamped[33], zero[39:34]
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   push_type         push;
   pop_type          head;
   logic             pop;
   logic             queue_full;
   logic [SOC_W-1:0] rsp_soc;
   logic             rsp_clamped;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CHARGE_GAIN:   cfg_in.charge_gain = csr_wdata;
            CSR_ETA_CHARGE:    cfg_in.chg_eff     = clamp_eta(csr_wdata);
            CSR_ETA_DISCHARGE: cfg_in.dis_eff     = clamp_eta(csr_wdata);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.charge_gain <= '0;
         cfg_ff.chg_eff     <= ETA_RESET;
         cfg_ff.dis_eff     <= ETA_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccsoc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .current_ma (req_tdata[CUR_W-1:0]),
      .time_us    (req_tdata[CUR_W+TIME_W-1:CUR_W]),
      .queue_full (queue_full),
      .push       (push)
   );

   ccsoc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   ccsoc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_soc     (rsp_soc),
      .rsp_clamped (rsp_clamped)
   );

   assign rsp_tdata = {{(RSP_DATA_W - SOC_W - 1){1'b0}}, rsp_clamped, rsp_soc};

endmodule

// ===== design/ccsoc_front.sv =====
// Front end: accepts samples, tracks the previous sample and classifies each request.
module ccsoc_front
   import ccsoc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [CUR_W-1:0]  current_ma,
   input  logic [TIME_W-1:0]        time_us,
   input  logic                     queue_full,
   output push_type                 push
);

   logic                     primed_ff, primed_in;
   logic [TIME_W-1:0]        last_time_ff, last_time_in;
   logic signed [CUR_W-1:0]  last_cur_ff, last_cur_in;
   logic signed [SUM_W-1:0]  sum;
   logic                     accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign sum       = SUM_W'(last_cur_ff) + SUM_W'(current_ma);

   always_comb begin
      primed_in    = primed_ff;
      last_time_in = last_time_ff;
      last_cur_in  = last_cur_ff;
      if (accept) begin
         primed_in    = 1'b1;
         last_time_in = time_us;
         last_cur_in  = current_ma;
      end
      push.push           = accept;
      push.data.first     = !primed_ff;
      push.data.discharge = (sum > 0);
      push.data.round_up  = (sum < 0);
      push.data.abs_sum   = (sum < 0) ? SUM_W'(-sum) : SUM_W'(sum);
      push.data.dt        = time_us - last_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         last_time_ff <= '0;
         last_cur_ff  <= '0;
      end else begin
         primed_ff    <= primed_in;
         last_time_ff <= last_time_in;
         last_cur_ff  <= last_cur_in;
      end
   end

endmodule

// ===== design/ccsoc_queue.sv =====
// Small request queue between front and back ends.
module ccsoc_queue
   import ccsoc_pkg::*;
#(
   parameter int unsigned DEPTH = 2
)
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output pop_type  head,
   output logic     full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.data  = mem_ff[rd_ptr_ff];
   assign do_push    = push.push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/ccsoc_back.sv =====
// Back end: multiply sequence, efficiency scaling and saturating SOC update.
module ccsoc_back
   import ccsoc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  pop_type          head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [SOC_W-1:0] rsp_soc,
   output logic             rsp_clamped
);

   back_state_type    state_ff, state_in;
   item_type          item_ff, item_in;
   logic [PART_W-1:0] p_lo_ff, p_lo_in;
   logic [PART_W-1:0] p_hi_ff, p_hi_in;
   logic [PROD_W-1:0] a_ff, a_in;
   logic [PROD_W-1:0] lo_ff, lo_in;
   logic [PROD_W-1:0] hi_ff, hi_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic [MAG_W-1:0]  step_ff, step_in;
   logic [SOC_W-1:0]  soc_ff, soc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SOC_W-1:0]  rsp_soc_ff, rsp_soc_in;
   logic              rsp_clamped_ff, rsp_clamped_in;

   logic              out_free;
   logic [PROD_W:0]   r_sum;
   logic [ETA_W-1:0]  eta;
   logic [MAG_W+ETA_W-1:0] eta_prod;
   logic [MAG_W-1:0]  room;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_soc     = rsp_soc_ff;
   assign rsp_clamped = rsp_clamped_ff;

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      p_lo_in        = p_lo_ff;
      p_hi_in        = p_hi_ff;
      a_in           = a_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mag_in         = mag_ff;
      step_in        = step_ff;
      soc_in         = soc_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_soc_in     = rsp_soc_ff;
      rsp_clamped_in = rsp_clamped_ff;
      pop            = 1'b0;
      r_sum          = {1'b0, hi_ff} + (PROD_W + 1)'(lo_ff[63:32])
                     + (PROD_W + 1)'(item_ff.round_up && (lo_ff[31:0] != '0));
      eta            = item_ff.discharge ? cfg.dis_eff : cfg.chg_eff;
      eta_prod       = (MAG_W + ETA_W)'(mag_ff) * (MAG_W + ETA_W)'(eta);
      room           = MAG_W'(SOC_FULL - soc_ff);

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               item_in = head.data;
               step_in = '0;
               state_in = head.data.first ? ST_UPDATE : ST_MUL_DL;
            end
         end
         ST_MUL_DL: begin
            p_lo_in  = PART_W'(item_ff.abs_sum) * PART_W'(item_ff.dt[HALF_W-1:0]);
            state_in = ST_MUL_DH;
         end
         ST_MUL_DH: begin
            p_hi_in  = PART_W'(item_ff.abs_sum) * PART_W'(item_ff.dt[TIME_W-1:HALF_W]);
            state_in = ST_ADD_A;
         end
         ST_ADD_A: begin
            a_in     = PROD_W'(p_lo_ff) + {p_hi_ff[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}};
            state_in = ST_MUL_GL;
         end
         ST_MUL_GL: begin
            lo_in    = PROD_W'(a_ff[31:0]) * PROD_W'(cfg.charge_gain);
            state_in = ST_MUL_GH;
         end
         ST_MUL_GH: begin
            hi_in    = PROD_W'(a_ff[63:32]) * PROD_W'(cfg.charge_gain);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            mag_in   = (r_sum > (PROD_W + 1)'(MAG_CAP)) ? MAG_CAP : r_sum[MAG_W-1:0];
            state_in = ST_MUL_ETA;
         end
         ST_MUL_ETA: begin
            step_in  = eta_prod[MAG_W+15:16];
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_clamped_in = 1'b0;
               if (item_ff.discharge) begin
                  if (step_ff > MAG_W'(soc_ff)) begin
                     soc_in         = '0;
                     rsp_clamped_in = 1'b1;
                  end else begin
                     soc_in = soc_ff - step_ff[SOC_W-1:0];
                  end
               end else begin
                  if (step_ff > room) begin
                     soc_in         = SOC_FULL;
                     rsp_clamped_in = 1'b1;
                  end else begin
                     soc_in = soc_ff + step_ff[SOC_W-1:0];
                  end
               end
               rsp_soc_in   = soc_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         soc_ff       <= SOC_FULL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         soc_ff       <= soc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      p_lo_ff        <= p_lo_in;
      p_hi_ff        <= p_hi_in;
      a_ff           <= a_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mag_ff         <= mag_in;
      step_ff        <= step_in;
      rsp_soc_ff     <= rsp_soc_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   a_soc_in_range: assert property (@(posedge clock) disable iff (reset)
      soc_ff <= SOC_FULL)
      else $error("soc level above full");

   a_clamp_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_clamped_ff |-> rsp_soc_ff == '0 || rsp_soc_ff == SOC_FULL)
      else $error("clamped result not at a rail");

   a_mag_capped: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM |=> mag_ff <= MAG_CAP)
      else $error("magnitude above cap");

endmodule
